// ===== hw/rtl/ffa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the first-fit arena allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int unsigned ARENA_BYTES  = 4096;
   localparam int unsigned ADDR_W       = 12;
   localparam int unsigned SIZE_W       = 13;
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned HOP_LIMIT    = ARENA_BYTES / 12 + 2;
   localparam int unsigned HOP_W        = 9;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_FILL  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_A_CHECK,
      ST_A_RDNX,
      ST_A_RDSZ,
      ST_A_END,
      ST_A_DECIDE,
      ST_A_HDR0,
      ST_A_HDR1,
      ST_A_HDR2,
      ST_A_FIX1,
      ST_A_FIX2,
      ST_F_RDNX,
      ST_F_RDPV,
      ST_F_RDSZ,
      ST_F_LINK,
      ST_F_BACK,
      ST_F_END,
      ST_F_ZERO,
      ST_L_START,
      ST_L_RDSZ,
      ST_L_END,
      ST_L_WRITE,
      ST_L_RDNX,
      ST_L_NEXT,
      ST_R_READ,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_RD_WORD,
      ACC_WR_WORD,
      ACC_WR_BYTE,
      ACC_CLEAR
   } acc_type;

   typedef enum logic [3:0] {
      AS_CUR,
      AS_CUR8,
      AS_END,
      AS_END4,
      AS_END8,
      AS_NX4,
      AS_HDR,
      AS_HDR4,
      AS_HDR8,
      AS_PV,
      AS_POS
   } asel_type;

   typedef enum logic [2:0] {
      WS_NX,
      WS_CUR,
      WS_AMOUNT,
      WS_END,
      WS_PV
   } wsel_type;

   typedef enum logic {
      RES_ALLOC,
      RES_BYTE
   } res_type;

   typedef enum logic [1:0] {
      KIND_EMPTY,
      KIND_PRE,
      KIND_TAIL,
      KIND_GAP
   } kind_type;

   typedef struct packed {
      acc_type  acc;
      asel_type asel;
      wsel_type wsel;
      logic     ld_req;
      logic     dispatch;
      logic     alloc_init;
      logic     ld_nx;
      logic     ld_pv;
      logic     ld_sz;
      logic     ld_end;
      logic     step_next;
      logic     fill_next;
      logic     byte_step;
      logic     free_first;
      logic     res_ld;
      res_type  res_sel;
      logic     rsp_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     acc_done;
      logic     clr_done;
      logic     too_big;
      logic     list_empty;
      logic     pre_fit;
      logic     nx_zero;
      logic     tail_fit;
      logic     gap_fit;
      logic     hop_last;
      logic     hop_max;
      logic     unlink_prev;
      logic     i_lt_end;
      logic     rem_zero;
      logic     rsp_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ffa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_if
// Valid/ready channels for requests, responses and the size register.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] amount;
   logic [11:0] position;
   logic [7:0]  fill_byte;
   modport source (output valid, output mode, output amount, output position,
                   output fill_byte, input ready);
   modport sink (input valid, input mode, input amount, input position,
                 input fill_byte, output ready);
endinterface

interface ffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] result_value;
   logic        granted;
   modport source (output valid, output result_value, output granted, input ready);
   modport sink (input valid, input result_value, input granted, output ready);
endinterface

interface ffa_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] used_bytes;
   modport source (output valid, output used_bytes, input ready);
   modport sink (input valid, input used_bytes, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ffa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer that steps the datapath through alloc, free, fill and read.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= KIND_EMPTY;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.mode)
               MODE_ALLOC: state_in = ST_A_CHECK;
               MODE_FREE:  state_in = ST_F_RDNX;
               MODE_FILL:  state_in = ST_L_START;
               default:    state_in = ST_R_READ;
            endcase
         end
         ST_A_CHECK: begin
            if (stat.too_big) begin
               state_in = ST_DONE;
            end else if (stat.list_empty) begin
               kind_in  = KIND_EMPTY;
               state_in = ST_A_HDR0;
            end else if (stat.pre_fit) begin
               kind_in  = KIND_PRE;
               state_in = ST_A_HDR0;
            end else begin
               state_in = ST_A_RDNX;
            end
         end
         ST_A_RDNX: if (stat.acc_done) state_in = ST_A_RDSZ;
         ST_A_RDSZ: if (stat.acc_done) state_in = ST_A_END;
         ST_A_END:  state_in = ST_A_DECIDE;
         ST_A_DECIDE: begin
            if (stat.nx_zero) begin
               if (stat.tail_fit) begin
                  kind_in  = KIND_TAIL;
                  state_in = ST_A_HDR0;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (stat.gap_fit) begin
               kind_in  = KIND_GAP;
               state_in = ST_A_HDR0;
            end else if (stat.hop_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_A_RDNX;
            end
         end
         ST_A_HDR0: if (stat.acc_done) state_in = ST_A_HDR1;
         ST_A_HDR1: if (stat.acc_done) state_in = ST_A_HDR2;
         ST_A_HDR2: begin
            if (stat.acc_done) begin
               unique case (kind_ff)
                  KIND_EMPTY: state_in = ST_DONE;
                  KIND_TAIL:  state_in = ST_A_FIX2;
                  default:    state_in = ST_A_FIX1;
               endcase
            end
         end
         ST_A_FIX1: begin
            if (stat.acc_done) begin
               state_in = (kind_ff == KIND_GAP) ? ST_A_FIX2 : ST_DONE;
            end
         end
         ST_A_FIX2: if (stat.acc_done) state_in = ST_DONE;
         ST_F_RDNX: if (stat.acc_done) state_in = ST_F_RDPV;
         ST_F_RDPV: if (stat.acc_done) state_in = ST_F_RDSZ;
         ST_F_RDSZ: if (stat.acc_done) state_in = ST_F_LINK;
         ST_F_LINK: begin
            if (!stat.unlink_prev || stat.acc_done) begin
               state_in = stat.nx_zero ? ST_F_END : ST_F_BACK;
            end
         end
         ST_F_BACK: if (stat.acc_done) state_in = ST_F_END;
         ST_F_END:  state_in = ST_F_ZERO;
         ST_F_ZERO: if (!stat.i_lt_end) state_in = ST_DONE;
         ST_L_START: state_in = stat.rem_zero ? ST_DONE : ST_L_RDSZ;
         ST_L_RDSZ: if (stat.acc_done) state_in = ST_L_END;
         ST_L_END:  state_in = ST_L_WRITE;
         ST_L_WRITE: begin
            if (stat.rem_zero) begin
               state_in = ST_DONE;
            end else if (!stat.i_lt_end) begin
               state_in = ST_L_RDNX;
            end
         end
         ST_L_RDNX: if (stat.acc_done) state_in = ST_L_NEXT;
         ST_L_NEXT: state_in = (stat.nx_zero || stat.hop_max) ? ST_DONE : ST_L_RDSZ;
         ST_R_READ: if (stat.acc_done) state_in = ST_DONE;
         ST_DONE:   if (stat.rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.acc   = ACC_NONE;
      cmd.asel  = AS_CUR;
      cmd.wsel  = WS_NX;
      cmd.res_sel = RES_ALLOC;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.acc = ACC_CLEAR;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.ld_req = req_valid;
         end
         ST_DISPATCH: cmd.dispatch = 1'b1;
         ST_A_CHECK: begin
            cmd.alloc_init = !stat.too_big && (stat.list_empty || stat.pre_fit);
         end
         ST_A_RDNX: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_CUR;
            cmd.ld_nx = 1'b1;
         end
         ST_A_RDSZ: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_CUR8;
            cmd.ld_sz = 1'b1;
         end
         ST_A_END: cmd.ld_end = 1'b1;
         ST_A_DECIDE: begin
            cmd.step_next = !stat.nx_zero && !stat.gap_fit && !stat.hop_last;
         end
         ST_A_HDR0: begin
            cmd.acc     = ACC_WR_WORD;
            cmd.asel    = AS_END;
            cmd.wsel    = WS_NX;
            cmd.res_ld  = 1'b1;
            cmd.res_sel = RES_ALLOC;
         end
         ST_A_HDR1: begin
            cmd.acc  = ACC_WR_WORD;
            cmd.asel = AS_END4;
            cmd.wsel = WS_CUR;
         end
         ST_A_HDR2: begin
            cmd.acc  = ACC_WR_WORD;
            cmd.asel = AS_END8;
            cmd.wsel = WS_AMOUNT;
         end
         ST_A_FIX1: begin
            cmd.acc  = ACC_WR_WORD;
            cmd.asel = AS_NX4;
            cmd.wsel = WS_END;
         end
         ST_A_FIX2: begin
            cmd.acc  = ACC_WR_WORD;
            cmd.asel = AS_CUR;
            cmd.wsel = WS_END;
         end
         ST_F_RDNX: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_HDR;
            cmd.ld_nx = 1'b1;
         end
         ST_F_RDPV: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_HDR4;
            cmd.ld_pv = 1'b1;
         end
         ST_F_RDSZ: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_HDR8;
            cmd.ld_sz = 1'b1;
         end
         ST_F_LINK: begin
            if (stat.unlink_prev) begin
               cmd.acc  = ACC_WR_WORD;
               cmd.asel = AS_PV;
               cmd.wsel = WS_NX;
            end else begin
               cmd.free_first = 1'b1;
            end
         end
         ST_F_BACK: begin
            cmd.acc  = ACC_WR_WORD;
            cmd.asel = AS_NX4;
            cmd.wsel = WS_PV;
         end
         ST_F_END: cmd.ld_end = 1'b1;
         ST_F_ZERO: begin
            if (stat.i_lt_end) begin
               cmd.acc       = ACC_WR_BYTE;
               cmd.byte_step = 1'b1;
            end
         end
         ST_L_START: ;
         ST_L_RDSZ: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_HDR8;
            cmd.ld_sz = 1'b1;
         end
         ST_L_END: cmd.ld_end = 1'b1;
         ST_L_WRITE: begin
            if (stat.i_lt_end && !stat.rem_zero) begin
               cmd.acc       = ACC_WR_BYTE;
               cmd.byte_step = 1'b1;
            end
         end
         ST_L_RDNX: begin
            cmd.acc   = ACC_RD_WORD;
            cmd.asel  = AS_HDR;
            cmd.ld_nx = 1'b1;
         end
         ST_L_NEXT: cmd.fill_next = !stat.nx_zero && !stat.hop_max;
         ST_R_READ: begin
            cmd.acc     = ACC_RD_WORD;
            cmd.asel    = AS_POS;
            cmd.res_ld  = stat.acc_done;
            cmd.res_sel = RES_BYTE;
         end
         ST_DONE: cmd.rsp_load = stat.rsp_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ffa_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_dpath
// Arena store, list registers, byte access engine and response register.
// ----------------------------------------------------------------------------
module ffa_dpath import ffa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_amount,
   input  wire logic [11:0] req_position,
   input  wire logic [7:0]  req_fill_byte,
   input  wire logic        csr_we,
   input  wire logic [12:0] csr_data,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [12:0]      rsp_result_value,
   output logic             rsp_granted
);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] first_ff, first_in;
   logic              nonempty_ff, nonempty_in;
   logic [SIZE_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        cnt_ff, cnt_in;

   mode_type          mode_ff, mode_in;
   logic [15:0]       amount_ff, amount_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [7:0]        fb_ff, fb_in;
   logic [16:0]       need_ff, need_in;
   logic [31:0]       cur_ff, cur_in;
   logic [31:0]       nx_ff, nx_in;
   logic [31:0]       pv_ff, pv_in;
   logic [31:0]       sz_ff, sz_in;
   logic [33:0]       end_ff, end_in;
   logic [31:0]       hdr_ff, hdr_in;
   logic [33:0]       i_ff, i_in;
   logic [15:0]       rem_ff, rem_in;
   logic [HOP_W-1:0]  hops_ff, hops_in;
   logic [31:0]       word_ff, word_in;
   logic [12:0]       res_ff, res_in;
   logic              gr_ff, gr_in;
   logic [12:0]       rsp_res_ff, rsp_res_in;
   logic              rsp_gr_ff, rsp_gr_in;

   logic              acc_done;
   logic              clr_done;
   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] word_addr;
   logic [31:0]       wword;
   logic [1:0]        cnt_m1;
   logic [31:0]       word_full;
   logic [33:0]       free_sum;
   logic [33:0]       free_stop;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   ffa_ram #(
      .WIDTH (8),
      .DEPTH (ARENA_BYTES)
   ) u_arena (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (word_addr),
      .rdata (ram_rdata)
   );

   assign clr_done  = (clr_ff == SIZE_W'(ARENA_BYTES));
   assign cnt_m1    = cnt_ff[1:0] - 2'd1;
   assign word_full = {ram_rdata, word_ff[23:0]};
   assign free_sum  = 34'(hdr_ff[ADDR_W-1:0]) + 34'(HEADER_BYTES) + 34'(sz_ff);
   assign free_stop = (free_sum > 34'(ARENA_BYTES)) ? 34'(ARENA_BYTES) : free_sum;

   always_comb begin
      case (cmd.acc)
         ACC_RD_WORD: acc_done = (cnt_ff == 3'd4);
         ACC_WR_WORD: acc_done = (cnt_ff == 3'd3);
         default:     acc_done = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cmd.asel)
         AS_CUR:  base = cur_ff[ADDR_W-1:0];
         AS_CUR8: base = cur_ff[ADDR_W-1:0] + 12'd8;
         AS_END:  base = end_ff[ADDR_W-1:0];
         AS_END4: base = end_ff[ADDR_W-1:0] + 12'd4;
         AS_END8: base = end_ff[ADDR_W-1:0] + 12'd8;
         AS_NX4:  base = nx_ff[ADDR_W-1:0] + 12'd4;
         AS_HDR:  base = hdr_ff[ADDR_W-1:0];
         AS_HDR4: base = hdr_ff[ADDR_W-1:0] + 12'd4;
         AS_HDR8: base = hdr_ff[ADDR_W-1:0] + 12'd8;
         AS_PV:   base = pv_ff[ADDR_W-1:0];
         AS_POS:  base = pos_ff;
         default: base = '0;
      endcase
   end

   assign word_addr = base + ADDR_W'(cnt_ff[1:0]);

   always_comb begin
      unique case (cmd.wsel)
         WS_NX:     wword = nx_ff;
         WS_CUR:    wword = cur_ff;
         WS_AMOUNT: wword = {16'd0, amount_ff};
         WS_END:    wword = end_ff[31:0];
         WS_PV:     wword = pv_ff;
         default:   wword = '0;
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = word_addr;
      ram_wdata = 8'd0;
      case (cmd.acc)
         ACC_WR_WORD: begin
            ram_we = 1'b1;
            case (cnt_ff[1:0])
               2'd0:    ram_wdata = wword[7:0];
               2'd1:    ram_wdata = wword[15:8];
               2'd2:    ram_wdata = wword[23:16];
               default: ram_wdata = wword[31:24];
            endcase
         end
         ACC_WR_BYTE: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff[ADDR_W-1:0];
            ram_wdata = (mode_ff == MODE_FILL) ? fb_ff : 8'd0;
         end
         ACC_CLEAR: begin
            ram_we    = !clr_done;
            ram_waddr = clr_ff[ADDR_W-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      size_in      = size_ff;
      first_in     = first_ff;
      nonempty_in  = nonempty_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      cnt_in       = 3'd0;
      mode_in      = mode_ff;
      amount_in    = amount_ff;
      pos_in       = pos_ff;
      fb_in        = fb_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      nx_in        = nx_ff;
      pv_in        = pv_ff;
      sz_in        = sz_ff;
      end_in       = end_ff;
      hdr_in       = hdr_ff;
      i_in         = i_ff;
      rem_in       = rem_ff;
      hops_in      = hops_ff;
      word_in      = word_ff;
      res_in       = res_ff;
      gr_in        = gr_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_gr_in    = rsp_gr_ff;

      if (csr_we) begin
         size_in = (csr_data > SIZE_W'(ARENA_BYTES)) ? SIZE_W'(ARENA_BYTES) : csr_data;
      end
      if (cmd.acc == ACC_CLEAR && !clr_done) begin
         clr_in = clr_ff + 13'd1;
      end
      if ((cmd.acc == ACC_RD_WORD || cmd.acc == ACC_WR_WORD) && !acc_done) begin
         cnt_in = cnt_ff + 3'd1;
      end
      if (cmd.acc == ACC_RD_WORD && cnt_ff != 3'd0) begin
         word_in[{cnt_m1, 3'b000} +: 8] = ram_rdata;
      end

      if (cmd.ld_req) begin
         mode_in   = mode_type'(req_mode);
         amount_in = req_amount;
         pos_in    = req_position;
         fb_in     = req_fill_byte;
         need_in   = {1'b0, req_amount} + 17'(HEADER_BYTES);
      end
      if (cmd.dispatch) begin
         cur_in  = {20'd0, first_ff};
         hops_in = '0;
         i_in    = {22'd0, pos_ff};
         rem_in  = amount_ff;
         res_in  = '0;
         gr_in   = 1'b0;
         if (mode_ff == MODE_FREE) begin
            hdr_in = {20'd0, pos_ff - 12'(HEADER_BYTES)};
         end else begin
            hdr_in = {20'd0, pos_ff} + 32'(ARENA_BYTES - HEADER_BYTES);
         end
      end
      if (cmd.alloc_init) begin
         cur_in = '0;
         end_in = '0;
         if (!nonempty_ff && first_ff == '0) begin
            nonempty_in = 1'b1;
            nx_in       = '0;
         end else begin
            nx_in    = {20'd0, first_ff};
            first_in = '0;
         end
      end
      if (acc_done && cmd.ld_nx) begin
         nx_in = word_full;
      end
      if (acc_done && cmd.ld_pv) begin
         pv_in = word_full;
      end
      if (acc_done && cmd.ld_sz) begin
         sz_in = word_full;
      end
      if (cmd.ld_end) begin
         case (mode_ff)
            MODE_ALLOC: end_in = {2'b00, cur_ff} + 34'(HEADER_BYTES) + {2'b00, sz_ff};
            MODE_FILL:  end_in = i_ff + {2'b00, sz_ff};
            default: begin
               end_in = free_stop;
               i_in   = {22'd0, hdr_ff[ADDR_W-1:0]};
            end
         endcase
      end
      if (cmd.step_next) begin
         cur_in  = nx_ff;
         hops_in = hops_ff + 1'b1;
      end
      if (cmd.fill_next) begin
         hops_in = hops_ff + 1'b1;
         hdr_in  = nx_ff;
         i_in    = {2'b00, nx_ff} + 34'(HEADER_BYTES);
      end
      if (cmd.byte_step) begin
         i_in   = i_ff + 34'd1;
         rem_in = rem_ff - 16'd1;
      end
      if (cmd.free_first) begin
         if (nx_ff != '0) begin
            first_in = nx_ff[ADDR_W-1:0];
         end else begin
            first_in    = '0;
            nonempty_in = 1'b0;
         end
      end
      if (cmd.res_ld) begin
         if (cmd.res_sel == RES_ALLOC) begin
            res_in = end_ff[12:0] + 13'(HEADER_BYTES);
            gr_in  = 1'b1;
         end else begin
            res_in = {5'd0, word_full[7:0]};
            gr_in  = 1'b0;
         end
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res_ff;
         rsp_gr_in    = gr_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_W'(ARENA_BYTES);
         first_ff     <= '0;
         nonempty_ff  <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         size_ff      <= size_in;
         first_ff     <= first_in;
         nonempty_ff  <= nonempty_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      amount_ff  <= amount_in;
      pos_ff     <= pos_in;
      fb_ff      <= fb_in;
      need_ff    <= need_in;
      cur_ff     <= cur_in;
      nx_ff      <= nx_in;
      pv_ff      <= pv_in;
      sz_ff      <= sz_in;
      end_ff     <= end_in;
      hdr_ff     <= hdr_in;
      i_ff       <= i_in;
      rem_ff     <= rem_in;
      hops_ff    <= hops_in;
      word_ff    <= word_in;
      res_ff     <= res_in;
      gr_ff      <= gr_in;
      rsp_res_ff <= rsp_res_in;
      rsp_gr_ff  <= rsp_gr_in;
   end

   always_comb begin
      stat.mode        = mode_ff;
      stat.acc_done    = acc_done;
      stat.clr_done    = clr_done;
      stat.too_big     = {4'd0, size_ff} < need_ff;
      stat.list_empty  = !nonempty_ff && (first_ff == '0);
      stat.pre_fit     = {5'd0, first_ff} >= need_ff;
      stat.nx_zero     = (nx_ff == '0);
      stat.tail_fit    = ({1'b0, end_ff} + 35'(need_ff)) <= 35'(size_ff);
      stat.gap_fit     = ({2'b00, nx_ff} >= end_ff)
                         && (({2'b00, nx_ff} - end_ff) >= 34'(need_ff))
                         && stat.tail_fit;
      stat.hop_last    = (hops_ff == HOP_W'(HOP_LIMIT - 1));
      stat.hop_max     = (hops_ff == HOP_W'(HOP_LIMIT));
      stat.unlink_prev = (pv_ff != '0)
                         || ((first_ff == '0) && (hdr_ff[ADDR_W-1:0] != '0));
      stat.i_lt_end    = i_ff < end_ff;
      stat.rem_zero    = (rem_ff == '0);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_granted      = rsp_gr_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_arena_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_top
// First-fit block allocator over a 4096-byte arena with in-arena headers.
// ----------------------------------------------------------------------------
// Requests are handled one at a time, and every arena access goes through a
// single byte-wide RAM with a registered read, one byte per cycle, which sets
// the cost of each item. An alloc reads the next link and the size of each
// block it walks past, then writes the new header and the neighboring links.
// A free reads the header, relinks its neighbors and zeroes each header and
// data byte. A fill writes its bytes and reads the link and size of each
// block it enters. After reset the block zeroes the arena and takes no item
// until that is done; size register writes are accepted at any time.
// A finished response waits in an output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_top import ffa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   ffa_req_if.sink   req_ch,
   ffa_rsp_if.source rsp_ch,
   ffa_csr_if.sink   csr_ch
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_ch.mode),
      .req_amount       (req_ch.amount),
      .req_position     (req_ch.position),
      .req_fill_byte    (req_ch.fill_byte),
      .csr_we           (csr_ch.valid),
      .csr_data         (csr_ch.used_bytes),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_granted      (rsp_ch.granted)
   );

endmodule
`default_nettype wire

// ===== test/first_fit_arena_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_top_tb
// Checks the first-fit arena allocator against a behavioral arena model.
// ----------------------------------------------------------------------------
// Directed items cover the request extremes, every mode and the allocation
// cases: empty list, room before the first block, gaps, tail room, oversized
// requests and wrapped addresses. Random traffic then allocates, frees, fills
// and reads live blocks under several arena sizes, with bursty requests and
// a stalling response side. Every response is compared in order.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_top_tb import ffa_pkg::*; ();

   localparam longint unsigned ARENA  = 4096;
   localparam int unsigned     HOPS   = 4096 / 12 + 2;
   localparam longint          LIMIT  = 400_000_000;

   typedef struct {
      logic [12:0] value;
      logic        granted;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffa_req_if req_ch ();
   ffa_rsp_if rsp_ch ();
   ffa_csr_if csr_ch ();

   first_fit_arena_allocator_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #6 clock = ~clock;

   logic [7:0]       arena_bytes [0:4095];
   longint unsigned  head_block;
   bit               has_blocks;
   longint unsigned  size_limit;
   outcome_type      pending_results[$];
   int unsigned      live_blocks[$];
   int               error_count = 0;
   int               item_count = 0;
   int               grant_count = 0;
   int               result_count = 0;
   int               burst_left = 0;
   longint           cycle_count = 0;
   int               stall_phase = 0;

   function automatic longint unsigned peek32(longint unsigned a);
      longint unsigned v;
      v = 0;
      for (int k = 0; k < 4; k++) begin
         v |= longint'(arena_bytes[(a + k) % ARENA]) << (8 * k);
      end
      return v;
   endfunction

   function automatic void poke32(longint unsigned a, longint unsigned v);
      for (int k = 0; k < 4; k++) begin
         arena_bytes[(a + k) % ARENA] = v[8*k +: 8];
      end
   endfunction

   function automatic void place_header(longint unsigned at, longint unsigned nx,
                                        longint unsigned pv, longint unsigned sz);
      poke32(at, nx);
      poke32(at + 4, pv);
      poke32(at + 8, sz);
   endfunction

   function automatic longint unsigned model_alloc(longint unsigned amount);
      longint unsigned need, cur, nx, fin, old;
      need = amount + 12;
      if (size_limit < need) begin
         return 0;
      end
      if (head_block == 0 && !has_blocks) begin
         place_header(0, 0, 0, amount);
         has_blocks = 1'b1;
         return 12;
      end
      if (head_block >= need) begin
         old = head_block;
         place_header(0, old, 0, amount);
         head_block = 0;
         poke32(old + 4, 0);
         return 12;
      end
      cur = head_block;
      for (int h = 0; h < HOPS; h++) begin
         nx = peek32(cur);
         fin = cur + 12 + peek32(cur + 8);
         if (nx == 0) begin
            if (fin + need <= size_limit) begin
               place_header(fin, 0, cur, amount);
               poke32(cur, fin);
               return (fin + 12) & 64'hFFFF_FFFF;
            end
            return 0;
         end
         if (nx >= fin && nx - fin >= need && fin + need <= size_limit) begin
            place_header(fin, nx, cur, amount);
            poke32(nx + 4, fin);
            poke32(cur, fin);
            return (fin + 12) & 64'hFFFF_FFFF;
         end
         cur = nx;
      end
      return 0;
   endfunction

   function automatic void model_free(longint unsigned pos);
      longint unsigned h, nx, pv, sz, stop;
      h = (pos + ARENA - 12) % ARENA;
      nx = peek32(h);
      pv = peek32(h + 4);
      sz = peek32(h + 8);
      if (pv != 0 || (head_block == 0 && h != head_block)) begin
         poke32(pv, nx);
      end else if (nx != 0) begin
         head_block = nx % ARENA;
      end else begin
         head_block = 0;
         has_blocks = 1'b0;
      end
      if (nx != 0) begin
         poke32(nx + 4, pv);
      end
      stop = h + 12 + sz;
      if (stop > ARENA) begin
         stop = ARENA;
      end
      for (longint unsigned i = h; i < stop; i++) begin
         arena_bytes[i] = 8'h00;
      end
   endfunction

   function automatic void model_fill(longint unsigned pos, longint unsigned amount,
                                      logic [7:0] b);
      longint unsigned hdr, i, fin, rem, nx;
      int hops;
      hdr = pos + ARENA - 12;
      i = pos;
      fin = pos + peek32(hdr + 8);
      rem = amount;
      hops = 0;
      while (rem > 0) begin
         while (i < fin && rem > 0) begin
            arena_bytes[i % ARENA] = b;
            i++;
            rem--;
         end
         nx = peek32(hdr);
         if (nx == 0 || hops >= HOPS) begin
            break;
         end
         hops++;
         hdr = nx;
         i = hdr + 12;
         fin = i + peek32(hdr + 8);
      end
   endfunction

   function automatic outcome_type model_request(mode_type mode, logic [15:0] amount,
                                                 logic [11:0] position, logic [7:0] b);
      outcome_type o;
      longint unsigned r;
      r = 0;
      o.granted = 1'b0;
      case (mode)
         MODE_ALLOC: begin
            r = model_alloc(64'(amount));
            o.granted = (r != 0);
         end
         MODE_FREE: model_free(64'(position));
         MODE_FILL: model_fill(64'(position), 64'(amount), b);
         default: r = 64'(arena_bytes[position]);
      endcase
      o.value = r[12:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("Mismatch on result %0d: %s is %0d, expected %0d", result_count, what,
               got, want);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count % 300 == 0) begin
         stall_phase <= $urandom_range(0, 3);
      end
      case (stall_phase)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
         2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ch.ready <= (cycle_count % 5) < 3;
      endcase
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            error_count++;
            $display("Unexpected result %0d with value %0d.", result_count,
                     rsp_ch.result_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.result_value !== want.value) begin
               report_mismatch("result_value", longint'(rsp_ch.result_value),
                               longint'(want.value));
            end
            if (rsp_ch.granted !== want.granted) begin
               report_mismatch("granted", longint'(rsp_ch.granted),
                               longint'(want.granted));
            end
         end
      end
   end

   task automatic send_request(mode_type mode, logic [15:0] amount, logic [11:0] position,
                               logic [7:0] b);
      outcome_type o;
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.amount <= amount;
      req_ch.position <= position;
      req_ch.fill_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      o = model_request(mode, amount, position, b);
      pending_results.push_back(o);
      item_count++;
      if (o.granted) begin
         grant_count++;
         live_blocks.push_back(32'(o.value));
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size_reg(logic [12:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.used_bytes <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      size_limit = (64'(value) > ARENA) ? ARENA : 64'(value);
      @(posedge clock);
   endtask

   task automatic free_live(int idx);
      int unsigned pos;
      pos = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(MODE_FREE, 16'($urandom), pos[11:0], 8'($urandom));
   endtask

   task automatic test_directed();
      send_request(MODE_READ, 16'h0000, 12'h000, 8'h00);
      send_request(MODE_READ, 16'hFFFF, 12'hFFF, 8'hFF);
      send_request(MODE_ALLOC, 16'hFFFF, 12'hFFF, 8'h00);
      send_request(MODE_ALLOC, 16'd4085, 12'h000, 8'h00);
      send_request(MODE_ALLOC, 16'd20, 12'h000, 8'h00);
      send_request(MODE_ALLOC, 16'd0, 12'h000, 8'h00);
      send_request(MODE_ALLOC, 16'd8, 12'h000, 8'h00);
      send_request(MODE_ALLOC, 16'd16, 12'h000, 8'h00);
      send_request(MODE_FILL, 16'hFFFF, 12'd12, 8'hFF);
      send_request(MODE_READ, 16'h0000, 12'd12, 8'h00);
      free_live(0);
      send_request(MODE_ALLOC, 16'd4, 12'h000, 8'h00);
      free_live(1);
      send_request(MODE_ALLOC, 16'd0, 12'h000, 8'h00);
      send_request(MODE_FILL, 16'd5, 12'd12, 8'hA5);
      send_request(MODE_FILL, 16'd0, 12'd12, 8'h5A);
      free_live(live_blocks.size() - 1);
      send_request(MODE_ALLOC, 16'd4000, 12'h000, 8'h00);
      send_request(MODE_READ, 16'h0000, 12'd13, 8'h00);
      while (live_blocks.size() != 0) free_live(0);
      send_request(MODE_ALLOC, 16'd4084, 12'h000, 8'h00);
      free_live(0);
      drain_results();
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         send_request(MODE_FREE, 16'($urandom), 12'($urandom), 8'($urandom));
      end else if (pick < 40 || live_blocks.size() == 0) begin
         if ($urandom_range(0, 99) < 2) begin
            send_request(MODE_ALLOC, 16'($urandom), 12'($urandom), 8'($urandom));
         end else if ($urandom_range(0, 9) == 0) begin
            send_request(MODE_ALLOC, 16'($urandom_range(0, 400)), 12'($urandom),
                         8'($urandom));
         end else begin
            send_request(MODE_ALLOC, 16'($urandom_range(0, 60)), 12'($urandom),
                         8'($urandom));
         end
      end else if (pick < 65) begin
         free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (pick < 83) begin
         send_request(MODE_FILL,
                      ($urandom_range(0, 49) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 100)),
                      12'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]),
                      8'($urandom));
      end else if (pick < 92) begin
         send_request(MODE_READ, 16'($urandom), 12'(live_blocks[$urandom_range(0,
                      live_blocks.size() - 1)] + $urandom_range(0, 20)), 8'($urandom));
      end else begin
         send_request(MODE_READ, 16'($urandom), 12'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) random_request();
      drain_results();
   endtask

   task automatic test_size_settings();
      write_size_reg(13'd16);
      test_random_traffic(60);
      write_size_reg(13'd0);
      test_random_traffic(30);
      write_size_reg(13'h1FFF);
      test_random_traffic(200);
      write_size_reg(13'($urandom_range(100, 2000)));
      test_random_traffic(200);
      write_size_reg(13'd4096);
   endtask

   task automatic test_full_pause();
      repeat (30) random_request();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      test_random_traffic(30);
   endtask

   initial begin
      for (int i = 0; i < 4096; i++) arena_bytes[i] = 8'h00;
      head_block = 0;
      has_blocks = 1'b0;
      size_limit = ARENA;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ALLOC;
      req_ch.amount = '0;
      req_ch.position = '0;
      req_ch.fill_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.used_bytes = 13'd4096;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(500);
      test_full_pause();
      test_size_settings();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d requests, %0d granted allocations, %0d results checked,",
               item_count, grant_count, result_count);
      $display("across arena sizes 0, 16, a random middle value, full and above full.");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_if.sv
hw/rtl/ffa_ram.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/ffa_dpath.sv
hw/rtl/first_fit_arena_allocator_top.sv
test/first_fit_arena_allocator_top_tb.sv
